[design/gbts_pkg.sv]
`timescale 1ns / 1ps

package gbts_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int PTR_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 11;
   localparam int LEN_W    = 11;
   localparam int CHAR_W   = 8;
   localparam int CMP_W    = (PTR_W > POS_W) ? PTR_W : POS_W;

   typedef enum logic [1:0] {
      REQ_INSERT       = 2'd0,
      REQ_REMOVE_ONE   = 2'd1,
      REQ_REMOVE_RANGE = 2'd2,
      REQ_READ         = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_BOUNDS = 2'd1,
      STATUS_FULL   = 2'd2
   } status_code_type;

   typedef struct packed {
      req_kind_type      req_type;
      logic [POS_W-1:0]  position;
      logic [POS_W-1:0]  range_end;
      logic [CHAR_W-1:0] char_in;
   } req_item_type;

   typedef struct packed {
      status_code_type   status;
      logic [CHAR_W-1:0] char_out;
      logic [LEN_W-1:0]  text_length;
   } rsp_item_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [CHAR_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_port_type;

endpackage

[design/gbts_char_ram.sv]
`timescale 1ns / 1ps

module gbts_char_ram
   import gbts_pkg::*;
(
   input  logic              clock,
   input  mem_port_type      mem_port,
   output logic [CHAR_W-1:0] rd_data
);

   logic [CHAR_W-1:0] mem_ff [CAPACITY];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_port.we) begin
         mem_ff[mem_port.waddr] <= mem_port.wdata;
      end
      rd_data_ff <= mem_ff[mem_port.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/gbts_engine.sv]
`timescale 1ns / 1ps

module gbts_engine
   import gbts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_item_type      req_data,
   input  logic              out_free,
   output logic              done_valid,
   output rsp_item_type      done_item,
   output mem_port_type      mem_port,
   input  logic [CHAR_W-1:0] rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOVE,
      S_APPLY,
      S_READ,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  gap_first_ff, gap_first_in;
   logic [PTR_W-1:0]  gap_past_ff, gap_past_in;
   req_kind_type      kind_ff, kind_in;
   logic [CMP_W-1:0]  pos_ff, pos_in;
   logic [CMP_W-1:0]  span_ff, span_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   status_code_type   status_ff, status_in;
   logic [CHAR_W-1:0] char_ff, char_in;

   logic [PTR_W-1:0]  gap_size;
   logic [PTR_W-1:0]  text_len;
   logic [CMP_W-1:0]  len_x;
   logic [CMP_W-1:0]  req_pos_x;
   logic [CMP_W-1:0]  req_end_x;
   logic [CMP_W-1:0]  gap_first_x;
   logic [CMP_W-1:0]  phys_x;
   logic [PTR_W-1:0]  gap_first_dec;
   logic [PTR_W-1:0]  gap_past_dec;
   logic              move_left;
   logic              at_target;

   assign gap_size    = gap_past_ff - gap_first_ff;
   assign text_len    = PTR_W'(CAPACITY) - gap_size;
   assign len_x       = CMP_W'(text_len);
   assign req_pos_x   = CMP_W'(req_data.position);
   assign req_end_x   = CMP_W'(req_data.range_end);
   assign gap_first_x = CMP_W'(gap_first_ff);
   // Physical cell of a read: positions at or past the gap skip over it.
   assign phys_x      = (req_pos_x < gap_first_x) ? req_pos_x
                                                  : req_pos_x + CMP_W'(gap_size);
   assign gap_first_dec = gap_first_ff - PTR_W'(1);
   assign gap_past_dec  = gap_past_ff - PTR_W'(1);
   assign move_left     = pos_ff < gap_first_x;
   assign at_target     = pos_ff == gap_first_x;

   always_comb begin
      state_in     = state_ff;
      gap_first_in = gap_first_ff;
      gap_past_in  = gap_past_ff;
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      span_in      = span_ff;
      ch_in        = ch_ff;
      pend_in      = 1'b0;
      wr_addr_in   = wr_addr_ff;
      status_in    = status_ff;
      char_in      = char_ff;

      mem_port.we    = 1'b0;
      mem_port.waddr = wr_addr_ff;
      mem_port.wdata = rd_data;
      mem_port.raddr = phys_x[ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_data.req_type;
               pos_in    = req_pos_x;
               span_in   = req_end_x - req_pos_x;
               ch_in     = req_data.char_in;
               char_in   = '0;
               status_in = STATUS_DONE;
               state_in  = S_MOVE;
               unique case (req_data.req_type)
                  REQ_INSERT: begin
                     if (req_pos_x > len_x) begin
                        status_in = STATUS_BOUNDS;
                        state_in  = S_DONE;
                     end else if (text_len >= PTR_W'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                        state_in  = S_DONE;
                     end
                  end
                  REQ_REMOVE_ONE: begin
                     if (req_pos_x >= len_x) begin
                        status_in = STATUS_BOUNDS;
                        state_in  = S_DONE;
                     end
                  end
                  REQ_REMOVE_RANGE: begin
                     if (req_pos_x > req_end_x || req_end_x > len_x) begin
                        status_in = STATUS_BOUNDS;
                        state_in  = S_DONE;
                     end
                  end
                  REQ_READ: begin
                     // The read address is presented this cycle; data lands next.
                     if (req_pos_x >= len_x) begin
                        status_in = STATUS_BOUNDS;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_MOVE: begin
            // A character read in the previous cycle is written to its new cell.
            mem_port.we = pend_ff;
            if (at_target) begin
               state_in = S_APPLY;
            end else if (move_left) begin
               mem_port.raddr = gap_first_dec[ADDR_W-1:0];
               wr_addr_in     = gap_past_dec[ADDR_W-1:0];
               pend_in        = 1'b1;
               gap_first_in   = gap_first_dec;
               gap_past_in    = gap_past_dec;
            end else begin
               mem_port.raddr = gap_past_ff[ADDR_W-1:0];
               wr_addr_in     = gap_first_ff[ADDR_W-1:0];
               pend_in        = 1'b1;
               gap_first_in   = gap_first_ff + PTR_W'(1);
               gap_past_in    = gap_past_ff + PTR_W'(1);
            end
         end
         S_APPLY: begin
            state_in = S_DONE;
            case (kind_ff)
               REQ_INSERT: begin
                  mem_port.we    = 1'b1;
                  mem_port.waddr = gap_first_ff[ADDR_W-1:0];
                  mem_port.wdata = ch_ff;
                  gap_first_in   = gap_first_ff + PTR_W'(1);
               end
               REQ_REMOVE_ONE: begin
                  gap_past_in = gap_past_ff + PTR_W'(1);
               end
               default: begin
                  gap_past_in = gap_past_ff + PTR_W'(span_ff);
               end
            endcase
         end
         S_READ: begin
            char_in  = rd_data;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gap_first_ff <= '0;
         gap_past_ff  <= PTR_W'(CAPACITY);
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gap_first_ff <= gap_first_in;
         gap_past_ff  <= gap_past_in;
         pend_ff      <= pend_in;
      end
      kind_ff    <= kind_in;
      pos_ff     <= pos_in;
      span_ff    <= span_in;
      ch_ff      <= ch_in;
      wr_addr_ff <= wr_addr_in;
      status_ff  <= status_in;
      char_ff    <= char_in;
   end

   assign req_ready             = state_ff == S_IDLE;
   assign done_valid            = state_ff == S_DONE;
   assign done_item.status      = status_ff;
   assign done_item.char_out    = char_ff;
   assign done_item.text_length = LEN_W'(text_len);

endmodule

[design/gap_buffer_text_store.sv]
`timescale 1ns / 1ps
// A rejected request goes from idle straight to its result; a read passes a read state.
// An insert or removal first moves the gap by distance d to the position, then applies;
// the gap is shifted one character per cycle through the character memory port.
// Requests are handled one at a time, the next accepted once the result is registered.
// Reset leaves an empty text with the gap over the whole store; memory is not cleared.

module gap_buffer_text_store
   import gbts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   mem_port_type      mem_port;
   logic [CHAR_W-1:0] rd_data;
   logic              done_valid;
   rsp_item_type      done_item;
   logic              out_free;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_data_ff, rsp_data_in;

   gbts_char_ram u_char_ram (
      .clock    (clock),
      .mem_port (mem_port),
      .rd_data  (rd_data)
   );

   gbts_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .out_free   (out_free),
      .done_valid (done_valid),
      .done_item  (done_item),
      .mem_port   (mem_port),
      .rd_data    (rd_data)
   );

   // The result register frees up in the same cycle its transfer completes.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = done_valid;
         rsp_data_in  = done_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("engine stayed ready after a request transfer");

   a_len_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.text_length <= LEN_W'(CAPACITY))
      else $error("reported text length exceeds capacity");

   a_char_zero_on_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_DONE |-> rsp_data.char_out == '0)
      else $error("rejected request returned a character");

   a_full_only_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_FULL
      |-> rsp_data.text_length == LEN_W'(CAPACITY))
      else $error("full status reported with room left");
`endif

endmodule
